@@ rtl/core/sql_comment_stripper_core_macros.svh @@
// Assertion macros for the SQL comment stripper core.
`ifndef SQL_COMMENT_STRIPPER_CORE_MACROS_SVH
`define SQL_COMMENT_STRIPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCC_ASSERT_IMP(label, ante, cons, msg)
`define SCC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/scc_pkg.sv @@
// Shared constants, types and helpers for the SQL comment stripper core.
package scc_pkg;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_HELD_SLASH = 3'd1;
    localparam logic [2:0] MODE_HELD_DASH  = 3'd2;
    localparam logic [2:0] MODE_BLOCK      = 3'd3;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd4;
    localparam logic [2:0] MODE_LINE       = 3'd5;
    localparam logic [2:0] MODE_QUOTE      = 3'd6;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;
    localparam logic [1:0] QUOTE_BACK   = 2'd3;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BQUOTE = 8'h60;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_text;
    } scc_result_t;

    typedef struct packed {
        logic [1:0]  count;
        scc_result_t first;
        scc_result_t second;
    } scc_step_t;

    function automatic logic [7:0] quote_char(input logic [1:0] q);
        logic [7:0] ch;
        case (q)
            QUOTE_DOUBLE: ch = CH_DQUOTE;
            QUOTE_SINGLE: ch = CH_SQUOTE;
            QUOTE_BACK:   ch = CH_BQUOTE;
            default:      ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/scc_scan.sv @@
// Per-byte scanner step: next mode, quote kind and up to two result bytes.
module scc_scan
    import scc_pkg::*;
(
    input  logic [2:0]  mode,
    input  logic [1:0]  quote,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic [2:0]  mode_next,
    output logic [1:0]  quote_next,
    output scc_step_t   step
);

    logic       p_emit;
    logic [2:0] p_mode;
    logic [1:0] p_quote;

    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
    logic [2:0] m;
    logic [1:0] q;
    logic [7:0] held;

    // Handling of a byte when no comment or quote is open.
    always_comb
    begin
        p_emit  = 1'b1;
        p_mode  = MODE_NORMAL;
        p_quote = quote;
        if (text_byte == CH_SLASH)
        begin
            p_emit = 1'b0;
            p_mode = MODE_HELD_SLASH;
        end
        else if (text_byte == CH_DASH)
        begin
            p_emit = 1'b0;
            p_mode = MODE_HELD_DASH;
        end
        else if (text_byte == CH_DQUOTE)
        begin
            p_mode  = MODE_QUOTE;
            p_quote = QUOTE_DOUBLE;
        end
        else if (text_byte == CH_SQUOTE)
        begin
            p_mode  = MODE_QUOTE;
            p_quote = QUOTE_SINGLE;
        end
        else if (text_byte == CH_BQUOTE)
        begin
            p_mode  = MODE_QUOTE;
            p_quote = QUOTE_BACK;
        end
    end

    always_comb
    begin
        b0   = 8'h00;
        b1   = 8'h00;
        n    = 2'd0;
        m    = mode;
        q    = quote;
        held = CH_DASH;
        case (mode)
            MODE_HELD_SLASH, MODE_HELD_DASH:
            begin
                if (mode == MODE_HELD_SLASH && text_byte == CH_STAR)
                begin
                    m = MODE_BLOCK;
                end
                else if (mode == MODE_HELD_DASH && text_byte == CH_DASH)
                begin
                    m = MODE_LINE;
                end
                else
                begin
                    b0 = (mode == MODE_HELD_SLASH) ? CH_SLASH : CH_DASH;
                    n  = 2'd1;
                    if (p_emit)
                    begin
                        b1 = text_byte;
                        n  = 2'd2;
                    end
                    m = p_mode;
                    q = p_quote;
                end
            end
            MODE_BLOCK:
            begin
                if (text_byte == CH_STAR)
                begin
                    m = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (text_byte == CH_SLASH)
                begin
                    m = MODE_NORMAL;
                end
                else if (text_byte != CH_STAR)
                begin
                    m = MODE_BLOCK;
                end
            end
            MODE_LINE:
            begin
                if (text_byte == CH_NL)
                begin
                    b0 = text_byte;
                    n  = 2'd1;
                    m  = MODE_NORMAL;
                end
            end
            MODE_QUOTE:
            begin
                b0 = text_byte;
                n  = 2'd1;
                if (text_byte == quote_char(quote))
                begin
                    q = QUOTE_NONE;
                    m = MODE_NORMAL;
                end
            end
            default:
            begin
                if (p_emit)
                begin
                    b0 = text_byte;
                    n  = 2'd1;
                end
                m = p_mode;
                q = p_quote;
            end
        endcase

        // A byte still held back at the end of the text is passed on last.
        if (final_byte)
        begin
            if (m == MODE_HELD_SLASH || m == MODE_HELD_DASH)
            begin
                held = (m == MODE_HELD_SLASH) ? CH_SLASH : CH_DASH;
                if (n == 2'd0)
                begin
                    b0 = held;
                    n  = 2'd1;
                end
                else if (n == 2'd1)
                begin
                    b1 = held;
                    n  = 2'd2;
                end
            end
            m = MODE_NORMAL;
            q = QUOTE_NONE;
        end

        mode_next  = m;
        quote_next = q;

        if (final_byte && n == 2'd0)
        begin
            step.count  = 2'd1;
            step.first  = '{out_byte: 8'h00, byte_present: 1'b0, end_of_text: 1'b1};
            step.second = '{out_byte: 8'h00, byte_present: 1'b0, end_of_text: 1'b0};
        end
        else
        begin
            step.count  = n;
            step.first  = '{out_byte: b0, byte_present: 1'b1,
                            end_of_text: final_byte && n == 2'd1};
            step.second = '{out_byte: b1, byte_present: 1'b1,
                            end_of_text: final_byte && n == 2'd2};
        end
    end

endmodule

@@ rtl/core/scc_fifo.sv @@
// Result queue that takes up to two results per cycle and gives one.
module scc_fifo
    import scc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  scc_step_t         wr_step,
    output logic              has_room,
    output logic [CNT_W-1:0]  level,
    output logic              rd_valid,
    output scc_result_t       rd_data,
    input  logic              rd_ready
);

    scc_result_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [1:0]         push_cnt;
    logic               pop;

    assign push_cnt   = wr_en ? wr_step.count : 2'd0;
    assign pop        = rd_valid && rd_ready;
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    assign has_room = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign level    = count_reg;
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_step.first;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= wr_step.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/sql_comment_stripper_core.sv @@
// SQL comment stripper: takes one text byte per transfer and returns the text
// without block and line comments, leaving quoted text untouched. A byte is
// taken in every cycle while the four-entry result queue has room for two
// results; they enter the queue at the next clock edge and leave it one per
// output transfer. A byte releasing a held slash or dash yields up to two,
// absorbed by the queue: one byte per cycle sustained while out_ready is high.
// The last byte of a text always yields at least one result flagged end_of_text.
`include "sql_comment_stripper_core_macros.svh"

module sql_comment_stripper_core
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_present,
    output logic        end_of_text
);

    logic [2:0]         mode_reg;
    logic [2:0]         mode_next;
    logic [1:0]         quote_reg;
    logic [1:0]         quote_next;
    scc_step_t          step;
    scc_result_t        head;
    logic               accept;
    logic [CNT_W-1:0]   level;

    assign accept = in_valid && in_ready;

    scc_scan u_scan (
        .mode       (mode_reg),
        .quote      (quote_reg),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .mode_next  (mode_next),
        .quote_next (quote_next),
        .step       (step)
    );

    scc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_step  (step),
        .has_room (in_ready),
        .level    (level),
        .rd_valid (out_valid),
        .rd_data  (head),
        .rd_ready (out_ready)
    );

    assign out_byte     = head.out_byte;
    assign byte_present = head.byte_present;
    assign end_of_text  = head.end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            quote_reg <= QUOTE_NONE;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
        end
    end

    `SCC_ASSERT_IMP(a_level_bound, 1'b1, level <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `SCC_ASSERT_NEXT(a_final_resets, accept && final_byte, mode_reg == MODE_NORMAL && quote_reg == QUOTE_NONE, "state not cleared after last byte")
    `SCC_ASSERT_IMP(a_quote_mode, 1'b1, (quote_reg != QUOTE_NONE) == (mode_reg == MODE_QUOTE), "quote kind and scan mode disagree")

endmodule
